// File: src/ula_pkg.sv
// Shared constants and controller/datapath interface types for the serial line assembler.
// No dependencies; imported by every module of the block.
package ula_pkg;

	localparam int LINE_SLOTS = 2;
	localparam int SLOT_BYTES = 20;
	localparam int LINE_CHARS = SLOT_BYTES - 2;
	localparam int MEM_DEPTH  = LINE_SLOTS * LINE_CHARS;

	localparam int SLOT_W = (LINE_SLOTS > 1) ? $clog2(LINE_SLOTS) : 1;
	localparam int SUM_W  = $clog2(2 * LINE_SLOTS);
	localparam int CNT_W  = $clog2(LINE_SLOTS + 1);
	localparam int LEN_W  = $clog2(LINE_CHARS + 1);
	localparam int ADDR_W = $clog2(MEM_DEPTH);
	localparam int PEND_W = 2;

	localparam logic [7:0] CR_BYTE    = 8'd13;
	localparam logic [7:0] PRINT_LOW  = 8'd32;
	localparam logic [7:0] PRINT_HIGH = 8'd122;

	localparam logic CMD_RX   = 1'b0;
	localparam logic CMD_TAKE = 1'b1;

	// commands from the controller to the datapath
	typedef struct packed {
		logic capture;
		logic rx_exec;
		logic take_open;
		logic mem_read;
		logic emit_char;
	} ctl_cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic is_take;
		logic take_has_chars;
		logic idx_last;
	} ctl_stat_t;

endpackage

// File: src/uart_line_assembler.sv
// Serial line assembler with echo: collects received bytes into a small ring of text
// lines and hands out completed lines on a take command. A transaction is accepted when
// start is high and busy is low. A received byte is captured, then executed; its single
// result strobes on result_valid in the same cycle as busy falls. A take reads its line
// through the single read port of the line memory: each character passes through a read
// state for the address and an emit state for the registered data; a take with no line
// pending or of an empty line gives one result. Results cannot be held off: each one is
// on the ports for exactly one cycle, and the final one of a transaction carries last.
// Every result reports lines_pending after the transaction. echo_enable is written
// through cfg_write/cfg_data; the user is to write it only while busy is low, which the
// block does not enforce. Depends on ula_pkg, ula_ctrl and ula_datapath.
module uart_line_assembler
	import ula_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic              command,
	input  logic [7:0]        rx_byte,
	input  logic              cfg_write,
	input  logic              cfg_data,
	output logic              result_valid,
	output logic              echo_valid,
	output logic [7:0]        echo_byte,
	output logic              rx_dropped,
	output logic              line_ready,
	output logic              char_valid,
	output logic [7:0]        line_char,
	output logic              last,
	output logic [PEND_W-1:0] lines_pending
);

	ctl_cmd_t  cmd;
	ctl_stat_t stat;

	ula_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	ula_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.command       (command),
		.rx_byte       (rx_byte),
		.cfg_write     (cfg_write),
		.cfg_data      (cfg_data),
		.result_valid  (result_valid),
		.echo_valid    (echo_valid),
		.echo_byte     (echo_byte),
		.rx_dropped    (rx_dropped),
		.line_ready    (line_ready),
		.char_valid    (char_valid),
		.line_char     (line_char),
		.last          (last),
		.lines_pending (lines_pending)
	);

	// a character that is not the last one is followed by the next after a read and an emit
	a_char_stream: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !last |-> ##2 result_valid)
		else $error("line character stream broken");

	// only take characters may leave a transaction open
	a_open_is_char: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !last |-> char_valid && line_ready && busy)
		else $error("non-final result outside a line take");

	// a dropped byte is never echoed and closes its transaction
	a_drop_no_echo: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && rx_dropped |-> !echo_valid && !char_valid && last)
		else $error("dropped byte echoed or left open");

	// an accepted transaction always blocks the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy && !result_valid)
		else $error("controller did not take the transaction");

endmodule

// File: src/ula_ctrl.sv
// Controller state machine of the serial line assembler.
// Depends on ula_pkg for the command and status structs.
module ula_ctrl
	import ula_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  ctl_stat_t stat,
	output ctl_cmd_t  cmd,
	output logic      busy
);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_EXEC = 4'b0010,
		S_READ = 4'b0100,
		S_EMIT = 4'b1000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		busy          = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.capture = 1'b1;
					state_d     = S_EXEC;
				end
			end
			S_EXEC: begin
				if (stat.is_take) begin
					cmd.take_open = 1'b1;
					state_d       = stat.take_has_chars ? S_READ : S_IDLE;
				end else begin
					cmd.rx_exec = 1'b1;
					state_d     = S_IDLE;
				end
			end
			S_READ: begin
				cmd.mem_read = 1'b1;
				state_d      = S_EMIT;
			end
			S_EMIT: begin
				cmd.emit_char = 1'b1;
				state_d       = stat.idx_last ? S_IDLE : S_READ;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// File: src/ula_datapath.sv
// Datapath of the serial line assembler: line memory, slot lengths, queue pointers
// and result registers. Depends on ula_pkg; driven by ula_ctrl commands.
module ula_datapath
	import ula_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  ctl_cmd_t          cmd,
	output ctl_stat_t         stat,
	input  logic              command,
	input  logic [7:0]        rx_byte,
	input  logic              cfg_write,
	input  logic              cfg_data,
	output logic              result_valid,
	output logic              echo_valid,
	output logic [7:0]        echo_byte,
	output logic              rx_dropped,
	output logic              line_ready,
	output logic              char_valid,
	output logic [7:0]        line_char,
	output logic              last,
	output logic [PEND_W-1:0] lines_pending
);

	logic              cmd_q;
	logic [7:0]        byte_q;
	logic              echo_en_q;
	logic [LEN_W-1:0]  slot_len_q [LINE_SLOTS];
	logic [CNT_W-1:0]  count_q;
	logic [SLOT_W-1:0] oldest_q;
	logic [SLOT_W-1:0] take_slot_q;
	logic [LEN_W-1:0]  take_len_q;
	logic [LEN_W-1:0]  idx_q;
	logic [7:0]        line_mem_q [MEM_DEPTH];
	logic [7:0]        rd_q;

	logic              res_valid_q;
	logic              echo_valid_q;
	logic [7:0]        echo_byte_q;
	logic              dropped_q;
	logic              ready_q;
	logic              cv_q;
	logic [7:0]        char_q;
	logic              last_q;
	logic [PEND_W-1:0] pend_q;

	logic [SUM_W-1:0]  slot_sum;
	logic [SLOT_W-1:0] build_slot;
	logic [SLOT_W-1:0] oldest_next;
	logic [LEN_W-1:0]  build_len;
	logic              slots_full;
	logic              is_cr;
	logic              printable;
	logic              line_has_room;
	logic              mem_we;
	logic [ADDR_W-1:0] wr_addr;
	logic [ADDR_W-1:0] rd_addr;
	logic [CNT_W-1:0]  count_inc;
	logic [CNT_W-1:0]  count_dec;

	// the line under construction sits right after the completed ones in the ring
	assign slot_sum   = SUM_W'(oldest_q) + SUM_W'(count_q);
	assign build_slot = (slot_sum >= SUM_W'(LINE_SLOTS)) ?
		SLOT_W'(slot_sum - SUM_W'(LINE_SLOTS)) : SLOT_W'(slot_sum);
	assign oldest_next = (oldest_q == SLOT_W'(LINE_SLOTS - 1)) ?
		'0 : SLOT_W'(oldest_q + SLOT_W'(1));
	assign build_len     = slot_len_q[build_slot];
	assign slots_full    = (count_q == CNT_W'(LINE_SLOTS));
	assign is_cr         = (byte_q == CR_BYTE);
	assign printable     = (byte_q >= PRINT_LOW) && (byte_q <= PRINT_HIGH);
	assign line_has_room = (build_len < LEN_W'(LINE_CHARS));
	assign count_inc     = CNT_W'(count_q + CNT_W'(1));
	assign count_dec     = CNT_W'(count_q - CNT_W'(1));

	assign mem_we  = cmd.rx_exec && !slots_full && !is_cr && printable && line_has_room;
	assign wr_addr = ADDR_W'(ADDR_W'(build_slot) * ADDR_W'(LINE_CHARS) + ADDR_W'(build_len));
	assign rd_addr = ADDR_W'(ADDR_W'(take_slot_q) * ADDR_W'(LINE_CHARS) + ADDR_W'(idx_q));

	assign stat.is_take        = (cmd_q == CMD_TAKE);
	assign stat.take_has_chars = (count_q != '0) && (slot_len_q[oldest_q] != '0);
	assign stat.idx_last       = (LEN_W'(idx_q + LEN_W'(1)) == take_len_q);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			line_mem_q[wr_addr] <= byte_q;
		end
		if (cmd.mem_read) begin
			rd_q <= line_mem_q[rd_addr];
		end
	end

	// control state: queue pointers, slot lengths, echo enable, result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			echo_en_q   <= 1'b0;
			count_q     <= '0;
			oldest_q    <= '0;
			res_valid_q <= 1'b0;
			for (int i = 0; i < LINE_SLOTS; i++) begin
				slot_len_q[i] <= '0;
			end
		end else begin
			res_valid_q <= cmd.rx_exec || cmd.take_open && !stat.take_has_chars ||
				cmd.emit_char;
			if (cfg_write) begin
				echo_en_q <= cfg_data;
			end
			if (cmd.rx_exec && !slots_full) begin
				if (is_cr) begin
					count_q <= count_inc;
				end else if (printable) begin
					if (line_has_room) begin
						slot_len_q[build_slot] <= LEN_W'(build_len + LEN_W'(1));
					end else begin
						count_q <= count_inc;
					end
				end
			end
			// free the oldest slot; the partial line elsewhere stays
			if (cmd.take_open && count_q != '0) begin
				slot_len_q[oldest_q] <= '0;
				oldest_q             <= oldest_next;
				count_q              <= count_dec;
			end
		end
	end

	// transaction payload and result fields
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cmd_q  <= command;
			byte_q <= rx_byte;
		end
		if (cmd.take_open) begin
			take_slot_q <= oldest_q;
			take_len_q  <= slot_len_q[oldest_q];
			idx_q       <= '0;
		end
		if (cmd.emit_char) begin
			idx_q <= LEN_W'(idx_q + LEN_W'(1));
		end

		if (cmd.rx_exec) begin
			ready_q <= 1'b0;
			cv_q    <= 1'b0;
			char_q  <= '0;
			last_q  <= 1'b1;
			if (slots_full) begin
				echo_valid_q <= 1'b0;
				echo_byte_q  <= '0;
				dropped_q    <= 1'b1;
				pend_q       <= PEND_W'(count_q);
			end else begin
				echo_valid_q <= echo_en_q;
				echo_byte_q  <= echo_en_q ? byte_q : 8'd0;
				dropped_q    <= 1'b0;
				if (is_cr || printable && !line_has_room) begin
					pend_q <= PEND_W'(count_inc);
				end else begin
					pend_q <= PEND_W'(count_q);
				end
			end
		end
		if (cmd.take_open) begin
			echo_valid_q <= 1'b0;
			echo_byte_q  <= '0;
			dropped_q    <= 1'b0;
			cv_q         <= 1'b0;
			char_q       <= '0;
			last_q       <= 1'b1;
			ready_q      <= (count_q != '0);
			pend_q       <= (count_q != '0) ? PEND_W'(count_dec) : PEND_W'(count_q);
		end
		if (cmd.emit_char) begin
			echo_valid_q <= 1'b0;
			echo_byte_q  <= '0;
			dropped_q    <= 1'b0;
			ready_q      <= 1'b1;
			cv_q         <= 1'b1;
			char_q       <= rd_q;
			last_q       <= stat.idx_last;
			pend_q       <= PEND_W'(count_q);
		end
	end

	assign result_valid  = res_valid_q;
	assign echo_valid    = echo_valid_q;
	assign echo_byte     = echo_byte_q;
	assign rx_dropped    = dropped_q;
	assign line_ready    = ready_q;
	assign char_valid    = cv_q;
	assign line_char     = char_q;
	assign last          = last_q;
	assign lines_pending = pend_q;

endmodule

// File: tb/uart_line_assembler_tb.sv
// Self-checking testbench for uart_line_assembler: a queue-fed driver, a result monitor
// and a line-ring predictor. Depends on ula_pkg and the uart_line_assembler RTL.
`timescale 1ns / 1ps

module uart_line_assembler_tb
	import ula_pkg::*;
();

	localparam int RANDOM_ITEMS  = 320;
	localparam int CALM_ITEMS    = 40;
	localparam int SETTLE_CYCLES = 3;
	localparam int TAIL_CYCLES   = 40;
	localparam int LIMIT_CYCLES  = 200000;

	typedef enum {ST_ITEM, ST_ECHO_CFG, ST_DRAIN} stim_kind_t;

	typedef struct {
		stim_kind_t kind;
		logic       cmd;
		logic [7:0] data;
		int         gap;
	} stim_t;

	typedef struct packed {
		logic              echo_valid;
		logic [7:0]        echo_byte;
		logic              rx_dropped;
		logic              line_ready;
		logic              char_valid;
		logic [7:0]        line_char;
		logic              last;
		logic [PEND_W-1:0] lines_pending;
	} line_result_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              command = CMD_RX;
	logic [7:0]        rx_byte = 8'd0;
	logic              cfg_write = 1'b0;
	logic              cfg_data = 1'b0;
	logic              busy;
	logic              result_valid;
	logic              echo_valid;
	logic [7:0]        echo_byte;
	logic              rx_dropped;
	logic              line_ready;
	logic              char_valid;
	logic [7:0]        line_char;
	logic              last;
	logic [PEND_W-1:0] lines_pending;

	uart_line_assembler i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.command      (command),
		.rx_byte      (rx_byte),
		.cfg_write    (cfg_write),
		.cfg_data     (cfg_data),
		.result_valid (result_valid),
		.echo_valid   (echo_valid),
		.echo_byte    (echo_byte),
		.rx_dropped   (rx_dropped),
		.line_ready   (line_ready),
		.char_valid   (char_valid),
		.line_char    (line_char),
		.last         (last),
		.lines_pending(lines_pending)
	);

	// predicted state of the line ring
	logic [7:0]   line_text [LINE_SLOTS][LINE_CHARS];
	int           line_len [LINE_SLOTS];
	int           lines_done = 0;
	int           head_slot = 0;
	logic         echo_on = 1'b0;

	stim_t        pending_ops[$];
	line_result_t pending_results[$];
	int           results_due = 0;
	int           results_taken = 0;
	int           errors = 0;
	int           cycle_count = 0;

	// driver state
	stim_t        cur;
	bit           have_cur = 0;
	int           gap_left = 0;
	int           settle = 0;
	logic         next_start;
	logic         next_cfg;

	// stimulus build state
	int           item_count = 0;
	bit           idle_on = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		for (int s = 0; s < LINE_SLOTS; s++)
			line_len[s] = 0;
	end

	task automatic queue_result(input line_result_t r);
		pending_results.push_back(r);
		results_due++;
	endtask

	task automatic predict_line_step(input logic cmd, input logic [7:0] data);
		line_result_t r;
		int slot;
		int len;
		r = '0;
		if (cmd == CMD_RX) begin
			if (lines_done >= LINE_SLOTS) begin
				r.rx_dropped = 1'b1;
			end else begin
				slot = (head_slot + lines_done) % LINE_SLOTS;
				if (data == CR_BYTE) begin
					lines_done++;
				end else if (data >= PRINT_LOW && data <= PRINT_HIGH) begin
					len = line_len[slot];
					if (len < LINE_CHARS) begin
						line_text[slot][len] = data;
						line_len[slot] = len + 1;
					end else begin
						// line full: complete it, lose the byte
						lines_done++;
					end
				end
				if (echo_on) begin
					r.echo_valid = 1'b1;
					r.echo_byte  = data;
				end
			end
			r.last = 1'b1;
			r.lines_pending = lines_done[PEND_W-1:0];
			queue_result(r);
		end else if (lines_done == 0) begin
			r.last = 1'b1;
			queue_result(r);
		end else begin
			slot = head_slot;
			len = line_len[slot];
			line_len[slot] = 0;
			head_slot = (slot + 1) % LINE_SLOTS;
			lines_done--;
			if (len == 0) begin
				r.line_ready = 1'b1;
				r.last = 1'b1;
				r.lines_pending = lines_done[PEND_W-1:0];
				queue_result(r);
			end else begin
				for (int i = 0; i < len; i++) begin
					r = '0;
					r.line_ready = 1'b1;
					r.char_valid = 1'b1;
					r.line_char = line_text[slot][i];
					r.last = (i == len - 1);
					r.lines_pending = lines_done[PEND_W-1:0];
					queue_result(r);
				end
			end
		end
	endtask

	task automatic compare_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (got !== want) begin
			$display("%0t: mismatch on %s: expected %0d, actual %0d", $time, name, want, got);
			errors++;
		end
	endtask

	// driver: one transaction or register write at a time from pending_ops
	always @(posedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
			cfg_write <= 1'b0;
		end else begin
			next_start = start;
			next_cfg = 1'b0;
			if (start && !busy) begin
				predict_line_step(command, rx_byte);
				next_start = 1'b0;
				have_cur = 0;
			end
			if (!next_start) begin
				if (!have_cur && pending_ops.size() != 0) begin
					cur = pending_ops.pop_front();
					have_cur = 1;
					gap_left = cur.gap;
					settle = 0;
				end
				if (have_cur) begin
					if (gap_left != 0) begin
						gap_left--;
					end else if (cur.kind == ST_ITEM) begin
						next_start = 1'b1;
						command <= cur.cmd;
						rx_byte <= cur.data;
					end else if (results_due == results_taken && !busy) begin
						// hold until the block has stayed quiet while settle counts up to SETTLE_CYCLES
						if (settle < SETTLE_CYCLES) begin
							settle++;
						end else begin
							if (cur.kind == ST_ECHO_CFG) begin
								next_cfg = 1'b1;
								cfg_data <= cur.data[0];
								echo_on = cur.data[0];
							end
							have_cur = 0;
						end
					end else begin
						settle = 0;
					end
				end
			end
			start <= next_start;
			cfg_write <= next_cfg;
		end
	end

	// monitor: every strobed result against the oldest expectation
	always @(posedge clk) begin
		line_result_t want;
		if (arst_n && result_valid) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result: expected none, actual line_char %0d last %0d",
					$time, line_char, last);
				errors++;
			end else begin
				want = pending_results.pop_front();
				compare_field("echo_valid", 8'(want.echo_valid), 8'(echo_valid));
				compare_field("echo_byte", want.echo_byte, echo_byte);
				compare_field("rx_dropped", 8'(want.rx_dropped), 8'(rx_dropped));
				compare_field("line_ready", 8'(want.line_ready), 8'(line_ready));
				compare_field("char_valid", 8'(want.char_valid), 8'(char_valid));
				compare_field("line_char", want.line_char, line_char);
				compare_field("last", 8'(want.last), 8'(last));
				compare_field("lines_pending", 8'(want.lines_pending), 8'(lines_pending));
				results_taken <= results_taken + 1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic add_item(input logic cmd, input logic [7:0] data);
		stim_t op;
		op.kind = ST_ITEM;
		op.cmd  = cmd;
		op.data = data;
		op.gap  = (idle_on && $urandom_range(0, 2) == 0) ? $urandom_range(1, 8) : 0;
		pending_ops.push_back(op);
		item_count++;
	endtask

	task automatic add_pause(input stim_kind_t kind, input logic value);
		stim_t op;
		op.kind = kind;
		op.cmd  = CMD_RX;
		op.data = {7'd0, value};
		op.gap  = 0;
		pending_ops.push_back(op);
	endtask

	function automatic logic [7:0] noise_byte();
		if ($urandom_range(0, 3) == 0)
			return 8'($urandom_range(0, 255));
		else if ($urandom_range(0, 1) == 0)
			return 8'($urandom_range(0, 31));
		else
			return 8'($urandom_range(123, 255));
	endfunction

	initial begin
		int round;
		int len;
		int pick;
		logic echo_next;

		// directed: empty ring and an empty line with echo off
		add_item(CMD_TAKE, 8'd0);
		add_item(CMD_RX, CR_BYTE);
		add_item(CMD_TAKE, 8'd255);
		add_pause(ST_ECHO_CFG, 1'b1);
		// printable bounds, ignored bytes, then a line filled to the brim
		add_item(CMD_RX, PRINT_LOW);
		add_item(CMD_RX, PRINT_LOW - 8'd1);
		add_item(CMD_RX, PRINT_HIGH);
		add_item(CMD_RX, PRINT_HIGH + 8'd1);
		add_item(CMD_RX, 8'd0);
		add_item(CMD_RX, 8'd255);
		for (int k = 0; k < LINE_CHARS - 2; k++)
			add_item(CMD_RX, 8'd97 + k[7:0]);
		add_item(CMD_RX, 8'd81);
		// second line empty, ring full: both bytes dropped
		add_item(CMD_RX, CR_BYTE);
		add_item(CMD_RX, 8'd66);
		add_item(CMD_RX, CR_BYTE);
		add_item(CMD_TAKE, 8'd0);
		add_item(CMD_TAKE, 8'd0);
		add_item(CMD_TAKE, 8'd0);

		round = 0;
		echo_next = 1'b0;
		while (item_count < RANDOM_ITEMS) begin
			idle_on = ($urandom_range(0, 3) != 0) && (item_count < RANDOM_ITEMS - CALM_ITEMS);
			if (round % 15 == 14) begin
				add_pause(ST_ECHO_CFG, echo_next);
				echo_next = ~echo_next;
			end
			if (round == 30)
				add_pause(ST_DRAIN, 1'b0);
			pick = $urandom_range(0, 9);
			if (pick < 6) begin
				// one line with random content, mostly short
				len = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 6) :
					$urandom_range(LINE_CHARS - 3, LINE_CHARS + 3);
				for (int j = 0; j < len; j++) begin
					if ($urandom_range(0, 7) == 0)
						add_item(CMD_RX, noise_byte());
					add_item(CMD_RX, 8'($urandom_range(PRINT_LOW, PRINT_HIGH)));
				end
				if (len <= LINE_CHARS || $urandom_range(0, 1) == 0)
					add_item(CMD_RX, CR_BYTE);
			end else if (pick < 9) begin
				repeat ($urandom_range(1, 2))
					add_item(CMD_TAKE, 8'($urandom_range(0, 255)));
			end else begin
				add_item(CMD_RX, noise_byte());
			end
			round++;
		end
		// drain whatever lines are left
		idle_on = 0;
		repeat (LINE_SLOTS + 1)
			add_item(CMD_TAKE, 8'd0);

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		do begin
			@(posedge clk);
			#1;
		end while (pending_ops.size() != 0 || have_cur || start || results_due != results_taken);
		repeat (TAIL_CYCLES) @(posedge clk);
		#1;
		if (pending_results.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time, pending_results.size());
			errors++;
		end
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
